// File: design/fvwm_pkg.sv
`default_nettype none

package fvwm_pkg;

	localparam int VOICES        = 4;
	localparam int VOICE_W       = 2;
	localparam int PHASE_W       = 24;
	localparam int STEP_W        = 16;
	localparam int INC_W         = 17;
	localparam int GAIN_W        = 16;
	localparam int BYTE_W        = 8;
	localparam int MIX_W         = 10;
	localparam int PROD_W        = MIX_W + GAIN_W;
	localparam int TABLE_ENTRIES = 256;
	localparam int OUT_DEPTH     = 4;
	localparam int OUT_PTR_W     = 2;
	localparam int OUT_CNT_W     = 3;

	localparam logic [STEP_W-1:0] STEP_RESET = 16'd1;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;
	localparam logic [INC_W-1:0]  FULL_STEP  = 17'h10000;
	localparam logic [BYTE_W-1:0] MID_LEVEL  = 8'h80;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_WRITE   = 2'd0;
	localparam func_t FUNC_RESTART = 2'd1;
	localparam func_t FUNC_SAMPLE  = 2'd2;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_STEP_A = 3'd0;
	localparam reg_idx_t REG_STEP_B = 3'd1;
	localparam reg_idx_t REG_STEP_C = 3'd2;
	localparam reg_idx_t REG_STEP_D = 3'd3;
	localparam reg_idx_t REG_GAIN   = 3'd4;

	localparam logic [VOICE_W-1:0] LAST_VOICE = 2'd3;

endpackage

`default_nettype wire

// File: design/fvwm_out_fifo.sv
`default_nettype none

module fvwm_out_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic [fvwm_pkg::BYTE_W-1:0]   din,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [fvwm_pkg::BYTE_W-1:0]        m_tdata  // [7:0] sample
);

	logic [fvwm_pkg::BYTE_W-1:0]    mem_q [fvwm_pkg::OUT_DEPTH];
	logic [fvwm_pkg::OUT_PTR_W-1:0] wr_ptr_q;
	logic [fvwm_pkg::OUT_PTR_W-1:0] rd_ptr_q;
	logic [fvwm_pkg::OUT_CNT_W-1:0] cnt_q;
	logic                           pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < fvwm_pkg::OUT_CNT_W'(fvwm_pkg::OUT_DEPTH)))
		else $error("output queue written while full");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("output queue pointers disagree with count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fvwm_pkg::OUT_CNT_W'(fvwm_pkg::OUT_DEPTH))
		else $error("output queue count out of range");

endmodule

`default_nettype wire

// File: design/four_voice_wavetable_mixer.sv
// Four-voice wavetable mixer.
// Requests arrive on the s_ stream: tdata[1:0] is the function, [9:2] the table
// entry and [17:10] the table byte. A table write and a phase restart produce
// nothing. A sample request advances the four phase accumulators one voice per
// cycle, reading the waveform table through its single read port, so a sample
// request holds off further requests until its last voice is being read. The
// 8-bit sample passes through the table reads, the mix, the multiply by gain and
// the output queue before it appears on the m_ stream. Results leave through a
// 4-entry queue; when the receiver stalls, up to four samples are held and
// further requests are refused once four samples are outstanding. Nothing is
// lost or repeated. Reset clears the phases to zero, sets every step to 1 and
// the gain to 16384, and empties the queue. The table contents are undefined
// until written. Steps and gain are to be written over the APB port while no
// request is in flight; the user must keep to this, the block does not enforce it.
`default_nettype none

module four_voice_wavetable_mixer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [1:0] func, [9:2] entry_index, [17:10] entry_value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] sample
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [fvwm_pkg::STEP_W-1:0]  step_q [fvwm_pkg::VOICES];
	logic [fvwm_pkg::GAIN_W-1:0]  gain_q;
	logic [fvwm_pkg::PHASE_W-1:0] phase_q [fvwm_pkg::VOICES];
	logic [fvwm_pkg::BYTE_W-1:0]  wave_mem [fvwm_pkg::TABLE_ENTRIES];

	logic                         busy_q;
	logic [fvwm_pkg::VOICE_W-1:0] voice_q;
	logic [fvwm_pkg::OUT_CNT_W-1:0] pend_q;

	logic                         rd_valid_s1;
	logic [fvwm_pkg::VOICE_W-1:0] rd_voice_s1;
	logic [fvwm_pkg::BYTE_W-1:0]  rd_data_s1;
	logic signed [fvwm_pkg::MIX_W-1:0]  acc_q;
	logic                         mix_valid_s2;
	logic signed [fvwm_pkg::MIX_W-1:0]  mix_s2;
	logic                         prod_valid_s3;
	logic signed [fvwm_pkg::PROD_W-1:0] prod_s3;

	fvwm_pkg::func_t              func;
	logic [7:0]                   entry_index;
	logic [7:0]                   entry_value;
	logic                         in_accept;
	logic                         take_sample;
	logic                         take_write;
	logic                         take_restart;
	logic                         out_accept;
	logic                         cfg_write;
	fvwm_pkg::reg_idx_t           cfg_idx;

	logic [fvwm_pkg::INC_W-1:0]   inc;
	logic [fvwm_pkg::PHASE_W-1:0] next_phase;
	logic signed [fvwm_pkg::MIX_W-1:0] voice_val;
	logic [fvwm_pkg::BYTE_W-1:0]  sample;

	assign func        = s_tdata[1:0];
	assign entry_index = s_tdata[9:2];
	assign entry_value = s_tdata[17:10];

	assign s_tready = (!busy_q || (voice_q == fvwm_pkg::LAST_VOICE))
	                  && (pend_q < fvwm_pkg::OUT_CNT_W'(fvwm_pkg::OUT_DEPTH));
	assign in_accept    = s_tvalid && s_tready;
	assign take_sample  = in_accept && (func == fvwm_pkg::FUNC_SAMPLE);
	assign take_write   = in_accept && (func == fvwm_pkg::FUNC_WRITE);
	assign take_restart = in_accept && (func == fvwm_pkg::FUNC_RESTART);
	assign out_accept   = m_tvalid && m_tready;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_idx   = paddr[4:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fvwm_pkg::VOICES; i++) begin
				step_q[i] <= fvwm_pkg::STEP_RESET;
			end
			gain_q <= fvwm_pkg::GAIN_RESET;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				fvwm_pkg::REG_STEP_A: step_q[0] <= pwdata[15:0];
				fvwm_pkg::REG_STEP_B: step_q[1] <= pwdata[15:0];
				fvwm_pkg::REG_STEP_C: step_q[2] <= pwdata[15:0];
				fvwm_pkg::REG_STEP_D: step_q[3] <= pwdata[15:0];
				fvwm_pkg::REG_GAIN:   gain_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			fvwm_pkg::REG_STEP_A: prdata = {16'h0, step_q[0]};
			fvwm_pkg::REG_STEP_B: prdata = {16'h0, step_q[1]};
			fvwm_pkg::REG_STEP_C: prdata = {16'h0, step_q[2]};
			fvwm_pkg::REG_STEP_D: prdata = {16'h0, step_q[3]};
			fvwm_pkg::REG_GAIN:   prdata = {{16{gain_q[15]}}, gain_q};
			default:              prdata = 32'h0;
		endcase
	end

	// Voice sequencer: one voice per cycle while a sample is being worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			voice_q <= '0;
		end else begin
			if (take_sample) begin
				busy_q  <= 1'b1;
				voice_q <= '0;
			end else if (busy_q) begin
				if (voice_q == fvwm_pkg::LAST_VOICE) begin
					busy_q <= 1'b0;
				end
				voice_q <= voice_q + 1'b1;
			end
		end
	end

	// A step of zero stands for a full table entry per sample.
	assign inc = (step_q[voice_q] == '0) ? fvwm_pkg::FULL_STEP
	                                       : {1'b0, step_q[voice_q]};
	assign next_phase = phase_q[voice_q] + {{(fvwm_pkg::PHASE_W-fvwm_pkg::INC_W){1'b0}}, inc};

	// A restart accepted in the last voice cycle follows that voice's update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fvwm_pkg::VOICES; i++) begin
				phase_q[i] <= '0;
			end
		end else if (take_restart) begin
			for (int i = 0; i < fvwm_pkg::VOICES; i++) begin
				phase_q[i] <= '0;
			end
		end else if (busy_q) begin
			phase_q[voice_q] <= next_phase;
		end
	end

	// Waveform table. A write accepted in the last voice cycle lands at the same
	// edge as that read, and the read sees the older byte, as request order wants.
	always_ff @(posedge clk) begin
		if (take_write) begin
			wave_mem[entry_index] <= entry_value;
		end
		rd_data_s1 <= wave_mem[next_phase[23:16]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1   <= 1'b0;
			rd_voice_s1   <= '0;
			mix_valid_s2  <= 1'b0;
			prod_valid_s3 <= 1'b0;
			pend_q        <= '0;
		end else begin
			rd_valid_s1   <= busy_q;
			rd_voice_s1   <= voice_q;
			mix_valid_s2  <= rd_valid_s1 && (rd_voice_s1 == fvwm_pkg::LAST_VOICE);
			prod_valid_s3 <= mix_valid_s2;
			case ({take_sample, out_accept})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	assign voice_val = $signed({2'b00, rd_data_s1}) - $signed({2'b00, fvwm_pkg::MID_LEVEL});

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			if (rd_voice_s1 == '0) begin
				acc_q <= voice_val;
			end else begin
				acc_q <= acc_q + voice_val;
			end
		end
		mix_s2  <= acc_q + voice_val;
		prod_s3 <= mix_s2 * $signed(gain_q);
	end

	// Bits 23:16 are the arithmetic shift by 16; adding 128 flips the top bit.
	assign sample = prod_s3[23:16] ^ fvwm_pkg::MID_LEVEL;

	fvwm_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (prod_valid_s3),
		.din      (sample),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (voice_q != fvwm_pkg::LAST_VOICE)) |-> !s_tready)
		else $error("request taken while voices are still being read");

	a_mix_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid_s2 |-> $past(rd_valid_s1 && (rd_voice_s1 == fvwm_pkg::LAST_VOICE)))
		else $error("mix produced without the last voice read");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q <= fvwm_pkg::OUT_CNT_W'(fvwm_pkg::OUT_DEPTH)) && (!m_tvalid || (pend_q != '0)))
		else $error("outstanding sample count out of range");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam fvwm_pkg::func_t FUNC_UNUSED = 2'd3;
	localparam int    WATCHDOG_LIMIT  = 5000;
	localparam int    HOLDOFF_CYCLES  = 300;
	localparam int    SETTLE_CYCLES   = 16;
	localparam int    PHASES          = 8;
	localparam int    PHASE_REQUESTS  = 190;
	localparam int    REPORT_LIMIT    = 10;

	typedef enum int {PACE_STEADY, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH} pace_t;

	typedef struct packed {
		fvwm_pkg::func_t func;
		logic [7:0]      idx;
		logic [7:0]      value;
		logic            typed;
		logic [7:0]      want;
	} request_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [1:0] func, [9:2] entry_index, [17:10] entry_value
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] sample
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	four_voice_wavetable_mixer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the mixer state.
	logic        [7:0]  wave_copy  [fvwm_pkg::TABLE_ENTRIES];
	logic        [23:0] phase_copy [fvwm_pkg::VOICES];
	logic        [15:0] step_copy  [fvwm_pkg::VOICES];
	logic signed [15:0] gain_copy;

	logic [7:0] expected_samples [$];

	pace_t pace;
	int    mismatches;
	int    idle_cycles;
	int    holdoff_asked;
	int    holdoff_served;
	int    n_samples;
	int    n_writes;
	int    n_restarts;
	int    n_ignored;
	int    n_checked;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [7:0] next_sample();
		int         mix;
		int         scaled;
		logic [16:0] inc;
		mix = 0;
		for (int v = 0; v < fvwm_pkg::VOICES; v++) begin
			inc = (step_copy[v] == '0) ? fvwm_pkg::FULL_STEP : {1'b0, step_copy[v]};
			phase_copy[v] = phase_copy[v] + 24'(inc);
			mix += int'(wave_copy[phase_copy[v][23:16]]) - 128;
		end
		// Arithmetic shift rounds toward minus infinity, as the block does.
		scaled = (mix * int'(gain_copy)) >>> 16;
		return 8'(scaled + 128);
	endfunction

	function automatic int sender_gap_pct();
		case (pace)
			PACE_SENDER_GAPS: return 70;
			PACE_BOTH:        return 30;
			default:          return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case (pace)
			PACE_RECEIVER_STALLS: return 70;
			PACE_BOTH:            return 30;
			default:              return 0;
		endcase
	endfunction

	// Waveform bytes lean on the extremes so that full-scale mixes turn up.
	function automatic logic [7:0] wave_byte();
		case ($urandom_range(3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void report_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch (%s): expected sample %0d, got %0d", what, want, got);
	endfunction

	task automatic send_request(input fvwm_pkg::func_t func, input logic [7:0] idx,
			input logic [7:0] value, input logic typed, input logic [7:0] want);
		int         pct;
		logic [7:0] sample;
		pct = sender_gap_pct();
		if (pct != 0 && $urandom_range(99) < pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, value, idx, func};
		do @(posedge clk); while (!s_tready);
		case (func)
			fvwm_pkg::FUNC_WRITE: begin
				wave_copy[idx] = value;
				n_writes++;
			end
			fvwm_pkg::FUNC_RESTART: begin
				foreach (phase_copy[v]) phase_copy[v] = '0;
				n_restarts++;
			end
			fvwm_pkg::FUNC_SAMPLE: begin
				sample = next_sample();
				expected_samples.push_back(typed ? want : sample);
				n_samples++;
			end
			default: n_ignored++;
		endcase
	endtask

	task automatic write_register(input fvwm_pkg::reg_idx_t idx, input logic [15:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == fvwm_pkg::REG_GAIN)
			gain_copy = value;
		else
			step_copy[idx] = value;
		@(posedge clk);
	endtask

	// Leaves the block idle: no request offered, every sample back, pipeline flushed.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure_phase(input int p);
		logic [15:0] steps [fvwm_pkg::VOICES];
		logic [15:0] level;
		case (p)
			1: begin
				foreach (steps[v]) steps[v] = 16'h0000;
				level = 16'h7FFF;
			end
			2: begin
				foreach (steps[v]) steps[v] = 16'hFFFF;
				level = 16'h8000;
			end
			3: begin
				foreach (steps[v]) steps[v] = 16'($urandom_range(16'hFFFF));
				level = 16'h0000;
			end
			4: begin
				steps = '{16'hFFFF, 16'h0001, 16'h8000, 16'h0000};
				level = 16'hFFFF;
			end
			6: begin
				foreach (steps[v]) steps[v] = 16'($urandom_range(1023));
				level = 16'($urandom_range(16'hFFFF));
			end
			7: begin
				steps = '{16'h0100, 16'h0000, 16'hFFFF, 16'h0001};
				level = 16'h4000;
			end
			default: begin
				foreach (steps[v]) steps[v] = 16'($urandom_range(16'hFFFF));
				level = 16'($urandom_range(16'hFFFF));
			end
		endcase
		write_register(fvwm_pkg::REG_STEP_A, steps[0]);
		write_register(fvwm_pkg::REG_STEP_B, steps[1]);
		write_register(fvwm_pkg::REG_STEP_C, steps[2]);
		write_register(fvwm_pkg::REG_STEP_D, steps[3]);
		write_register(fvwm_pkg::REG_GAIN, level);
	endtask

	task automatic run_random_phase(input int p);
		int              count;
		int              pick;
		fvwm_pkg::func_t func;
		logic            holdoff_done;
		logic            pause_done;
		count        = 0;
		holdoff_done = 1'b0;
		pause_done   = 1'b0;
		while (count < PHASE_REQUESTS) begin
			if (p == 2 && count == 20 && !holdoff_done) begin
				holdoff_asked++;
				holdoff_done = 1'b1;
			end
			if (p == 5 && count == PHASE_REQUESTS / 2 && !pause_done) begin
				s_tvalid <= 1'b0;
				while (expected_samples.size() != 0) @(posedge clk);
				@(posedge clk);
				pause_done = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 70)
				func = fvwm_pkg::FUNC_SAMPLE;
			else if (pick < 85)
				func = fvwm_pkg::FUNC_WRITE;
			else if (pick < 93)
				func = fvwm_pkg::FUNC_RESTART;
			else
				func = FUNC_UNUSED;
			send_request(func, 8'($urandom_range(255)),
				(func == fvwm_pkg::FUNC_WRITE) ? wave_byte() : 8'($urandom_range(255)),
				1'b0, 8'd0);
			if (func != FUNC_UNUSED)
				count++;
		end
	endtask

	initial begin
		// Directed requests: the first samples read entry 0 only, since every phase
		// starts at zero and steps by one after reset.
		request_row_t directed_rows [12];
		directed_rows = '{
			'{fvwm_pkg::FUNC_WRITE,   8'd0,   8'd0,   1'b0, 8'd0},
			'{fvwm_pkg::FUNC_SAMPLE,  8'd0,   8'd0,   1'b1, 8'd0},
			'{fvwm_pkg::FUNC_WRITE,   8'd0,   8'd255, 1'b0, 8'd0},
			'{fvwm_pkg::FUNC_SAMPLE,  8'd255, 8'd255, 1'b1, 8'd255},
			'{fvwm_pkg::FUNC_WRITE,   8'd0,   8'd128, 1'b0, 8'd0},
			'{fvwm_pkg::FUNC_SAMPLE,  8'd0,   8'd0,   1'b1, 8'd128},
			'{fvwm_pkg::FUNC_RESTART, 8'd255, 8'd255, 1'b0, 8'd0},
			'{fvwm_pkg::FUNC_SAMPLE,  8'd0,   8'd0,   1'b1, 8'd128},
			'{FUNC_UNUSED,            8'd0,   8'd0,   1'b0, 8'd0},
			'{fvwm_pkg::FUNC_SAMPLE,  8'd0,   8'd0,   1'b1, 8'd128},
			'{fvwm_pkg::FUNC_WRITE,   8'd255, 8'd255, 1'b0, 8'd0},
			'{fvwm_pkg::FUNC_WRITE,   8'd255, 8'd0,   1'b0, 8'd0}
		};

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		pace     = PACE_STEADY;
		foreach (phase_copy[v]) phase_copy[v] = '0;
		foreach (step_copy[v]) step_copy[v] = fvwm_pkg::STEP_RESET;
		gain_copy = fvwm_pkg::GAIN_RESET;
		foreach (wave_copy[i]) wave_copy[i] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].func, directed_rows[i].idx, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].want);

		// Fill the whole table so that later samples never read an unwritten entry.
		for (int i = 0; i < fvwm_pkg::TABLE_ENTRIES; i++)
			send_request(fvwm_pkg::FUNC_WRITE, 8'(i), wave_byte(), 1'b0, 8'd0);
		settle_block();

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0)
				configure_phase(p);
			pace = pace_t'(p % 4);
			run_random_phase(p);
			settle_block();
		end

		$display("Covered %0d samples, %0d table writes, %0d restarts and %0d ignored requests",
			n_samples, n_writes, n_restarts, n_ignored);
		$display("over %0d step and gain settings; %0d samples checked, %0d mismatches.",
			PHASES, n_checked, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Receiver side: random back-pressure, plus one long hold-off when asked.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_served < holdoff_asked) begin
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
				holdoff_served++;
			end else begin
				m_tready <= ($urandom_range(99) >= receiver_stall_pct());
			end
		end
	end

	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_samples.size() == 0) begin
				report_mismatch("no request pending", 8'd0, m_tdata);
			end else begin
				want = expected_samples.pop_front();
				n_checked++;
				if (m_tdata !== want)
					report_mismatch("sample", want, m_tdata);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: nothing moved for %0d cycles, %0d samples outstanding.",
				idle_cycles, expected_samples.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		mismatches     = 0;
		idle_cycles    = 0;
		holdoff_asked  = 0;
		holdoff_served = 0;
		n_samples      = 0;
		n_writes       = 0;
		n_restarts     = 0;
		n_ignored      = 0;
		n_checked      = 0;
	end

endmodule

`default_nettype wire

// File: sim.f
design/fvwm_pkg.sv
design/fvwm_out_fifo.sv
design/four_voice_wavetable_mixer.sv
sim/tb_top.sv
